>>> rtl/core/lcs_pkg.sv
// lcs_pkg: shared constants, request codes and controller/datapath interface types
// for the lcs distance engine. No dependencies.
`timescale 1ns / 1ps
package lcs_pkg;
   localparam int MAX_LEN = 128;
   localparam int IDX_W   = $clog2(MAX_LEN);
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int CHAR_W  = 8;
   localparam int CALC_W  = LEN_W + 2;
   localparam int FRAC_W  = 16;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_STEP   = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   typedef struct packed {
      logic load;
      logic step;
      logic sweep_start;
      logic sweep_run;
      logic fin_start;
      logic fin_calc;
      logic div_step;
      logic report;
   } lcs_cmd_type;

   typedef struct packed {
      logic n_full;
      logic m_zero;
      logic sweep_done;
      logic div_last;
   } lcs_status_type;
endpackage

>>> rtl/core/lcs_distance_engine.sv
// lcs_distance_engine top: a load is taken without going busy; a second-string char sweeps the row
// (one row entry per cycle through the row memory, m = first-string length; no sweep if m = 0).
// finish: from request to the edge that takes the result the engine does a row read, 16 divide
// steps and a report; the next request can be taken at that same edge.
// synchronous active-high reset: config to normalize=1 similarity=0, row and lengths clear.
// results are shown for one cycle on rsp_valid; the receiver cannot stall.
`timescale 1ns / 1ps
module lcs_distance_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_char_value,
   output logic        rsp_valid,
   output logic [7:0]  rsp_lcs_length,
   output logic [8:0]  rsp_raw_value,
   output logic [16:0] rsp_ratio_q16,
   output logic        rsp_both_empty,
   output logic        rsp_too_long,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import lcs_pkg::*;

   lcs_cmd_type    cmd;
   lcs_status_type status;
   logic           normalize_ff, similarity_ff;
   logic           csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         normalize_ff  <= 1'b1;
         similarity_ff <= 1'b0;
      end else if (csr_wr) begin
         if (paddr[2]) begin
            similarity_ff <= pwdata[0];
         end else begin
            normalize_ff <= pwdata[0];
         end
      end
   end

   assign prdata = {31'd0, paddr[2] ? similarity_ff : normalize_ff};

   lcs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .opcode(req_opcode),
      .status(status), .cmd(cmd), .busy(busy), .rsp_valid(rsp_valid)
   );

   lcs_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .char_value(req_char_value),
      .normalize(normalize_ff), .similarity(similarity_ff), .status(status),
      .lcs_length(rsp_lcs_length), .raw_value(rsp_raw_value),
      .ratio_q16(rsp_ratio_q16), .both_empty(rsp_both_empty),
      .too_long(rsp_too_long)
   );

`ifndef SYNTHESIS
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without finish in progress");
   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_FINISH) |=> busy)
      else $error("finish request did not start work");
   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ratio_q16 <= 17'h10000)) else $error("ratio above one");
   a_lcs_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_lcs_length <= 8'(MAX_LEN))) else $error("lcs too large");
`endif
endmodule

>>> rtl/core/lcs_ram.sv
// lcs_ram: generic single-write, single-read memory with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/core/lcs_ctrl.sv
// lcs_ctrl: request sequencer for the lcs engine (sweep, finish, divide, report).
// Depends on lcs_pkg.
`timescale 1ns / 1ps
module lcs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             opcode,
   input  lcs_pkg::lcs_status_type status,
   output lcs_pkg::lcs_cmd_type   cmd,
   output logic                   busy,
   output logic                   rsp_valid
);
   import lcs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SWEEP, ST_FREAD, ST_DIV, ST_REPORT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      cmd             = '0;
      cmd.load        = accept && (opcode == OP_LOAD);
      cmd.step        = accept && (opcode == OP_STEP);
      cmd.sweep_start = cmd.step && !status.n_full && !status.m_zero;
      cmd.sweep_run   = (state_ff == ST_SWEEP);
      cmd.fin_start   = accept && (opcode == OP_FINISH);
      cmd.fin_calc    = (state_ff == ST_FREAD);
      cmd.div_step    = (state_ff == ST_DIV);
      cmd.report      = (state_ff == ST_REPORT);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.sweep_start) begin
               state_in = ST_SWEEP;
            end else if (cmd.fin_start) begin
               state_in = ST_FREAD;
            end
         end
         ST_SWEEP: begin
            if (status.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_FREAD:  state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_last) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.report;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

>>> rtl/core/lcs_datapath.sv
// lcs_datapath: string store, dp row with valid bits, row sweep pipeline,
// finish arithmetic and radix-2 divider. Depends on lcs_pkg and lcs_ram.
`timescale 1ns / 1ps
module lcs_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  lcs_pkg::lcs_cmd_type   cmd,
   input  logic [7:0]             char_value,
   input  logic                   normalize,
   input  logic                   similarity,
   output lcs_pkg::lcs_status_type status,
   output logic [7:0]             lcs_length,
   output logic [8:0]             raw_value,
   output logic [16:0]            ratio_q16,
   output logic                   both_empty,
   output logic                   too_long
);
   import lcs_pkg::*;

   logic [LEN_W-1:0]  m_ff, m_in, n_ff, n_in;
   logic              ovf_ff, ovf_in;
   logic [CHAR_W-1:0] char_ff;
   logic [LEN_W-1:0]  iss_ff;
   logic              p1_valid_ff;
   logic [IDX_W-1:0]  p1_idx_ff;
   logic [LEN_W-1:0]  diag_ff, left_ff;
   logic [MAX_LEN-1:0] dpv_ff;

   logic [CHAR_W-1:0] fs_rdata;
   logic [LEN_W-1:0]  dp_rdata;
   logic [IDX_W-1:0]  fs_raddr, dp_raddr, m_last;
   logic              fs_we, dp_we, issue;
   logic [LEN_W-1:0]  up, v;

   // finish and divider
   logic [LEN_W-1:0]  lcs_ff;
   logic [8:0]        raw_ff;
   logic              norm_ff, empty_ff;
   logic [CALC_W-1:0] den_ff, rem_ff, rem2;
   logic [FRAC_W:0]   q_ff;
   logic [3:0]        cnt_ff;
   logic [LEN_W-1:0]  lcs_c;
   logic [CALC_W-1:0] mm, nn, ll, d_c, num_c, den_c;
   logic              q_top, bit_c;

   logic [7:0]  lcs_out_ff;
   logic [8:0]  raw_out_ff;
   logic [16:0] ratio_out_ff;
   logic        empty_out_ff, ovf_out_ff;

   assign m_last   = IDX_W'(m_ff - LEN_W'(1));
   assign issue    = cmd.sweep_run && (iss_ff < m_ff);
   assign fs_we    = cmd.load && (n_ff == '0) && (m_ff < LEN_W'(MAX_LEN));
   assign fs_raddr = cmd.sweep_start ? '0 : iss_ff[IDX_W-1:0];
   assign dp_raddr = cmd.fin_start ? m_last : fs_raddr;
   assign dp_we    = cmd.sweep_run && p1_valid_ff;

   lcs_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_first (
      .clock(clock), .we(fs_we), .waddr(m_ff[IDX_W-1:0]), .wdata(char_value),
      .raddr(fs_raddr), .rdata(fs_rdata)
   );

   lcs_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_row (
      .clock(clock), .we(dp_we), .waddr(p1_idx_ff), .wdata(v),
      .raddr(dp_raddr), .rdata(dp_rdata)
   );

   // entries never written since the last clear read as zero
   assign up = dpv_ff[p1_idx_ff] ? dp_rdata : '0;
   assign v  = (fs_rdata == char_ff) ? LEN_W'(diag_ff + LEN_W'(1))
                                     : ((up > left_ff) ? up : left_ff);

   always_comb begin
      m_in   = m_ff;
      n_in   = n_ff;
      ovf_in = ovf_ff;
      if (cmd.load && (n_ff == '0)) begin
         if (m_ff < LEN_W'(MAX_LEN)) begin
            m_in = LEN_W'(m_ff + LEN_W'(1));
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.step) begin
         if (n_ff < LEN_W'(MAX_LEN)) begin
            n_in = LEN_W'(n_ff + LEN_W'(1));
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.report) begin
         m_in   = '0;
         n_in   = '0;
         ovf_in = 1'b0;
      end
   end

   assign status.n_full     = (n_ff >= LEN_W'(MAX_LEN));
   assign status.m_zero     = (m_ff == '0);
   assign status.sweep_done = p1_valid_ff && (p1_idx_ff == m_last);
   assign status.div_last   = (cnt_ff == '0);

   // finish arithmetic on the row's last entry
   assign lcs_c = ((m_ff != '0) && dpv_ff[m_last]) ? dp_rdata : '0;
   assign mm    = CALC_W'(m_ff);
   assign nn    = CALC_W'(n_ff);
   assign ll    = CALC_W'(lcs_c);
   assign d_c   = CALC_W'(mm + nn - (ll << 1));
   assign num_c = similarity ? ll : CALC_W'(d_c << 1);
   assign den_c = similarity ? CALC_W'(mm + nn - ll) : CALC_W'(mm + nn + d_c);
   assign q_top = (den_c != '0) && (num_c >= den_c);
   assign rem2  = CALC_W'(rem_ff << 1);
   assign bit_c = (rem2 >= den_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff        <= '0;
         n_ff        <= '0;
         ovf_ff      <= 1'b0;
         p1_valid_ff <= 1'b0;
         dpv_ff      <= '0;
      end else begin
         m_ff   <= m_in;
         n_ff   <= n_in;
         ovf_ff <= ovf_in;
         if (cmd.sweep_start) begin
            p1_valid_ff <= 1'b1;
         end else if (cmd.sweep_run) begin
            p1_valid_ff <= issue;
         end
         if (cmd.report) begin
            dpv_ff <= '0;
         end else if (dp_we) begin
            dpv_ff[p1_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep_start) begin
         char_ff   <= char_value;
         iss_ff    <= LEN_W'(1);
         p1_idx_ff <= '0;
         diag_ff   <= '0;
         left_ff   <= '0;
      end else if (cmd.sweep_run) begin
         if (issue) begin
            iss_ff    <= LEN_W'(iss_ff + LEN_W'(1));
            p1_idx_ff <= iss_ff[IDX_W-1:0];
         end
         if (p1_valid_ff) begin
            diag_ff <= up;
            left_ff <= v;
         end
      end
      if (cmd.fin_calc) begin
         lcs_ff   <= lcs_c;
         raw_ff   <= similarity ? 9'(lcs_c) : 9'(d_c);
         norm_ff  <= normalize && (den_c != '0);
         empty_ff <= (m_ff == '0) && (n_ff == '0);
         den_ff   <= den_c;
         rem_ff   <= q_top ? CALC_W'(num_c - den_c) : num_c;
         q_ff     <= {{FRAC_W{1'b0}}, q_top};
         cnt_ff   <= 4'(FRAC_W - 1);
      end else if (cmd.div_step) begin
         rem_ff <= bit_c ? CALC_W'(rem2 - den_ff) : rem2;
         q_ff   <= {q_ff[FRAC_W-1:0], bit_c};
         cnt_ff <= 4'(cnt_ff - 4'd1);
      end
      if (cmd.report) begin
         lcs_out_ff   <= 8'(lcs_ff);
         raw_out_ff   <= raw_ff;
         ratio_out_ff <= norm_ff ? q_ff : '0;
         empty_out_ff <= empty_ff;
         ovf_out_ff   <= ovf_ff;
      end
   end

   assign lcs_length = lcs_out_ff;
   assign raw_value  = raw_out_ff;
   assign ratio_q16  = ratio_out_ff;
   assign both_empty = empty_out_ff;
   assign too_long   = ovf_out_ff;
endmodule
